// ----- hw/rtl/lens_distortion_point_correction_defines.svh -----
// Assertion helpers for the top-level RTL file.
`ifndef LENS_DISTORTION_POINT_CORRECTION_DEFINES_SVH
`define LENS_DISTORTION_POINT_CORRECTION_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define LPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- hw/rtl/lpc_pkg.sv -----
package lpc_pkg;

	localparam int FOCAL_W    = 20;
	localparam int CENTER_W   = 16;
	localparam int COEF_W     = 24;
	localparam int COORD_W    = 16;
	localparam int OUT_W      = 18;
	localparam int RECIP_W    = 32;
	localparam int RECIP_FRAC = 31;
	localparam int FOCAL_FRAC = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Numerator of the reciprocal is 2^39 + f/2, one quotient bit per step.
	localparam int DIV_W     = 40;
	localparam int DIV_CNT_W = 6;

	localparam logic [RECIP_W-1:0] RECIP_RESET = 32'h8000_0000;
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 20'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_K1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_K2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_P1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_P2 = 3'd7;

	typedef struct packed {
		logic                busy;
		logic [RECIP_W-1:0]  recip;
	} recip_stat_t;

endpackage

// ----- hw/rtl/lpc_recip.sv -----
module lpc_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpc_pkg::FOCAL_W-1:0] focal,
	output lpc_pkg::recip_stat_t        stat
);
	import lpc_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RECIP_W-1:0]   recip_q;
	logic [FOCAL_W-1:0]   den_q;
	logic [FOCAL_W-1:0]   rem_q;
	logic [DIV_W-1:0]     num_q;

	logic [FOCAL_W:0]   trial;
	logic               ge;
	logic [FOCAL_W-1:0] rem_nx;
	logic [DIV_W-1:0]   quo;
	logic [DIV_W-1:0]   numer;

	assign numer  = {1'b1, {(DIV_W-1){1'b0}}} + {{(DIV_W-FOCAL_W+1){1'b0}}, focal[FOCAL_W-1:1]};
	assign trial  = {rem_q, num_q[DIV_W-1]};
	assign ge     = trial >= {1'b0, den_q};
	assign rem_nx = ge ? FOCAL_W'(trial - {1'b0, den_q}) : trial[FOCAL_W-1:0];
	// Dividend bits shift out the top while quotient bits shift in below.
	assign quo    = {num_q[DIV_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			recip_q <= RECIP_RESET;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q  <= 1'b0;
				recip_q <= (|quo[DIV_W-1:RECIP_W]) ? '1 : quo[RECIP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= focal;
			rem_q <= '0;
			num_q <= numer;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= quo;
		end
	end

	assign stat.busy  = busy_q;
	assign stat.recip = recip_q;

endmodule

// ----- hw/rtl/lens_distortion_point_correction.sv -----
// Lens distortion correction for image-plane spots (radial k1, k2, tangential p1, p2).
// Input channel in_valid/in_ready carries raw_x, raw_y; output channel
// out_valid/out_ready carries fixed_x, fixed_y and clipped. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while
// no request is in flight; the block itself does not enforce this. A request
// passes eight register stages, which advance as a whole, the first capturing it
// at its accepting edge. Throughput: one request per cycle unless stalled or a
// divider is busy. Writing focal_x or focal_y starts a shift-subtract divider
// for the reciprocal; in_ready stays low until it finishes.
// Reset: focal 1.0, center and coefficients zero, reciprocals 1.0, pipeline
// empty; no clearing pass, requests are taken right after reset.
// Stall: while out_valid is high and out_ready low every stage holds and
// in_ready drops; nothing is lost or repeated.
`include "lens_distortion_point_correction_defines.svh"
module lens_distortion_point_correction #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int COEF_FRAC_BITS  = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lpc_pkg::COORD_W-1:0]         raw_x,
	input  logic [lpc_pkg::COORD_W-1:0]         raw_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lpc_pkg::OUT_W-1:0]    fixed_x,
	output logic signed [lpc_pkg::OUT_W-1:0]    fixed_y,
	output logic                                clipped
);
	import lpc_pkg::*;

	localparam int F    = COEF_FRAC_BITS;
	localparam int DXW  = COORD_W + 1;
	localparam int PNW  = DXW + RECIP_W + 1;
	localparam int NSH  = COORD_FRAC_BITS + RECIP_FRAC - F;
	localparam int NW   = F + 3;
	localparam int SW   = F + 6;
	localparam int R4W  = F + 8;
	localparam int KW   = COEF_W + 1;
	localparam int TW   = 32;
	localparam int DW   = 32;
	localparam int UW   = 34;
	localparam int PSH  = F + FOCAL_FRAC - COORD_FRAC_BITS;
	localparam int FW   = FOCAL_W + 1;

	localparam logic signed [63:0] NLIM    = 64'sd1 <<< (F + 1);
	localparam logic signed [63:0] OUT_HI  = 64'sd131071;
	localparam logic signed [63:0] OUT_LO  = -64'sd131072;
	localparam logic signed [63:0] ONE_F   = 64'sd1 <<< F;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// Configuration
	logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
	logic [CENTER_W-1:0] center_x_q, center_y_q;
	logic [COEF_W-1:0]   k1_q, k2_q, p1_q, p2_q;
	recip_stat_t         rx_stat, ry_stat;
	logic                start_x, start_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL_X:    focal_x_q  <= cfg_data[FOCAL_W-1:0];
				CFG_FOCAL_Y:    focal_y_q  <= cfg_data[FOCAL_W-1:0];
				CFG_CENTER_X:   center_x_q <= cfg_data[CENTER_W-1:0];
				CFG_CENTER_Y:   center_y_q <= cfg_data[CENTER_W-1:0];
				CFG_RADIAL_K1:  k1_q       <= cfg_data[COEF_W-1:0];
				CFG_RADIAL_K2:  k2_q       <= cfg_data[COEF_W-1:0];
				CFG_TANGENT_P1: p1_q       <= cfg_data[COEF_W-1:0];
				CFG_TANGENT_P2: p2_q       <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign start_x = cfg_we && (cfg_index == CFG_FOCAL_X);
	assign start_y = cfg_we && (cfg_index == CFG_FOCAL_Y);

	lpc_recip u_recip_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_x),
		.focal  (cfg_data[FOCAL_W-1:0]),
		.stat   (rx_stat)
	);

	lpc_recip u_recip_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_y),
		.focal  (cfg_data[FOCAL_W-1:0]),
		.stat   (ry_stat)
	);

	// Coefficients enter negated
	logic signed [KW-1:0] k1n, k2n, p1n, p2n;
	assign k1n = -$signed({k1_q[COEF_W-1], k1_q});
	assign k2n = -$signed({k2_q[COEF_W-1], k2_q});
	assign p1n = -$signed({p1_q[COEF_W-1], p1_q});
	assign p2n = -$signed({p2_q[COEF_W-1], p2_q});

	// Pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv;

	assign adv      = !v_s8 || out_ready;
	assign in_ready = adv && !rx_stat.busy && !ry_stat.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// Stage 1: offset by the principal point
	logic signed [DXW-1:0] dx_s1, dy_s1;

	// Stage 2: normalize and clamp to +-2.0
	logic signed [PNW-1:0] pnx, pny;
	logic signed [63:0]    nrx, nry, ncx, ncy;
	logic                  nclip;
	logic signed [NW-1:0]  nx_s2, ny_s2;
	logic                  clip_s2;

	assign pnx = dx_s1 * $signed({1'b0, rx_stat.recip});
	assign pny = dy_s1 * $signed({1'b0, ry_stat.recip});

	always_comb begin
		nrx   = rnd(64'(pnx), NSH);
		nry   = rnd(64'(pny), NSH);
		ncx   = nrx;
		ncy   = nry;
		nclip = 1'b0;
		if (nrx > NLIM) begin
			ncx = NLIM; nclip = 1'b1;
		end
		if (nrx < -NLIM) begin
			ncx = -NLIM; nclip = 1'b1;
		end
		if (nry > NLIM) begin
			ncy = NLIM; nclip = 1'b1;
		end
		if (nry < -NLIM) begin
			ncy = -NLIM; nclip = 1'b1;
		end
	end

	// Stage 3: second-order terms
	logic signed [2*NW-1:0] pxx, pyy, pxy;
	logic signed [63:0]     rxx, ryy, rxy;
	logic signed [SW-1:0]   x2_s3, y2_s3, xy_s3;
	logic signed [NW-1:0]   nx_s3, ny_s3;
	logic                   clip_s3;

	assign pxx = nx_s2 * nx_s2;
	assign pyy = ny_s2 * ny_s2;
	assign pxy = nx_s2 * ny_s2;
	assign rxx = rnd(64'(pxx), F);
	assign ryy = rnd(64'(pyy), F);
	assign rxy = rnd(64'(pxy), F);

	// Stage 4: r^2, r^4 and the tangential sums
	logic signed [SW-1:0]   r2c;
	logic signed [2*SW-1:0] pr4;
	logic signed [63:0]     rr4;
	logic signed [SW-1:0]   r2_s4, tx_s4, ty_s4, xy_s4;
	logic signed [R4W-1:0]  r4_s4;
	logic signed [NW-1:0]   nx_s4, ny_s4;
	logic                   clip_s4;

	assign r2c = x2_s3 + y2_s3;
	assign pr4 = r2c * r2c;
	assign rr4 = rnd(64'(pr4), F);

	// Stage 5: coefficient products
	logic signed [KW+SW-1:0]  pk1, pp1xy, pp2tx, pp1ty, pp2xy;
	logic signed [KW+R4W-1:0] pk2;
	logic signed [63:0]       rk1, rk2, ru1, ru2, rv1, rv2;
	logic signed [TW-1:0]     a1_s5, a2_s5, tu1_s5, tu2_s5, tv1_s5, tv2_s5;
	logic signed [NW-1:0]     nx_s5, ny_s5;
	logic                     clip_s5;

	assign pk1   = k1n * r2_s4;
	assign pk2   = k2n * r4_s4;
	assign pp1xy = p1n * xy_s4;
	assign pp2xy = p2n * xy_s4;
	assign pp2tx = p2n * tx_s4;
	assign pp1ty = p1n * ty_s4;
	assign rk1   = rnd(64'(pk1), F);
	assign rk2   = rnd(64'(pk2), F);
	assign ru1   = rnd(64'(pp1xy) <<< 1, F);
	assign ru2   = rnd(64'(pp2tx), F);
	assign rv1   = rnd(64'(pp1ty), F);
	assign rv2   = rnd(64'(pp2xy) <<< 1, F);

	// Stage 6: radial factor and tangential offsets
	logic signed [63:0]   dsum, usum, vsum;
	logic signed [DW-1:0] d_s6;
	logic signed [TW-1:0] tu_s6, tv_s6;
	logic signed [NW-1:0] nx_s6, ny_s6;
	logic                 clip_s6;

	assign dsum = ONE_F + 64'(a1_s5) + 64'(a2_s5);
	assign usum = 64'(tu1_s5) + 64'(tu2_s5);
	assign vsum = 64'(tv1_s5) + 64'(tv2_s5);

	// Stage 7: corrected normalized coordinates
	logic signed [NW+DW-1:0] pxd, pyd;
	logic signed [63:0]      un64, vn64;
	logic signed [UW-1:0]    un_s7, vn_s7;
	logic                    clip_s7;

	assign pxd  = nx_s6 * d_s6;
	assign pyd  = ny_s6 * d_s6;
	assign un64 = rnd(64'(pxd), F) + 64'(tu_s6);
	assign vn64 = rnd(64'(pyd), F) + 64'(tv_s6);

	// Stage 8: back to pixels and saturate
	logic signed [UW+FW-1:0] pfx, pfy;
	logic signed [63:0]      ox, oy, sx, sy;
	logic                    oclip;
	logic signed [OUT_W-1:0] fx_s8, fy_s8;
	logic                    clip_s8;

	assign pfx = un_s7 * $signed({1'b0, focal_x_q});
	assign pfy = vn_s7 * $signed({1'b0, focal_y_q});

	always_comb begin
		ox    = rnd(64'(pfx), PSH) + 64'($signed({1'b0, center_x_q}));
		oy    = rnd(64'(pfy), PSH) + 64'($signed({1'b0, center_y_q}));
		sx    = ox;
		sy    = oy;
		oclip = clip_s7;
		if (ox > OUT_HI) begin
			sx = OUT_HI; oclip = 1'b1;
		end
		if (ox < OUT_LO) begin
			sx = OUT_LO; oclip = 1'b1;
		end
		if (oy > OUT_HI) begin
			sy = OUT_HI; oclip = 1'b1;
		end
		if (oy < OUT_LO) begin
			sy = OUT_LO; oclip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= $signed({1'b0, raw_x}) - $signed({1'b0, center_x_q});
			dy_s1   <= $signed({1'b0, raw_y}) - $signed({1'b0, center_y_q});

			nx_s2   <= ncx[NW-1:0];
			ny_s2   <= ncy[NW-1:0];
			clip_s2 <= nclip;

			x2_s3   <= rxx[SW-1:0];
			y2_s3   <= ryy[SW-1:0];
			xy_s3   <= rxy[SW-1:0];
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			clip_s3 <= clip_s2;

			r2_s4   <= r2c;
			r4_s4   <= rr4[R4W-1:0];
			tx_s4   <= r2c + (x2_s3 <<< 1);
			ty_s4   <= r2c + (y2_s3 <<< 1);
			xy_s4   <= xy_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			clip_s4 <= clip_s3;

			a1_s5   <= rk1[TW-1:0];
			a2_s5   <= rk2[TW-1:0];
			tu1_s5  <= ru1[TW-1:0];
			tu2_s5  <= ru2[TW-1:0];
			tv1_s5  <= rv1[TW-1:0];
			tv2_s5  <= rv2[TW-1:0];
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			clip_s5 <= clip_s4;

			d_s6    <= dsum[DW-1:0];
			tu_s6   <= usum[TW-1:0];
			tv_s6   <= vsum[TW-1:0];
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			clip_s6 <= clip_s5;

			un_s7   <= un64[UW-1:0];
			vn_s7   <= vn64[UW-1:0];
			clip_s7 <= clip_s6;

			fx_s8   <= sx[OUT_W-1:0];
			fy_s8   <= sy[OUT_W-1:0];
			clip_s8 <= oclip;
		end
	end

	assign out_valid = v_s8;
	assign fixed_x   = fx_s8;
	assign fixed_y   = fy_s8;
	assign clipped   = clip_s8;

	`LPC_ASSERT_NOW(a_busy_blocks_in, clk, arst_n, rx_stat.busy || ry_stat.busy, !in_ready)
	`LPC_ASSERT_NEXT(a_focal_starts_div, clk, arst_n, start_x, rx_stat.busy)
	`LPC_ASSERT_NEXT(a_stall_holds, clk, arst_n, v_s1 && !adv, v_s1)
	`LPC_ASSERT_NEXT(a_valid_moves, clk, arst_n, adv, v_s2 == $past(v_s1))

endmodule
